// ----- sv/tssa_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, constants and lookup functions of the track segmentation block.
// Depends on nothing; the design files refer to it by scoped names.
package tssa_pkg;

	// Widths fixed by the item fields.
	localparam int PosW   = 24;
	localparam int DiffW  = 25;
	localparam int OperW  = 32;
	localparam int ProdW  = 64;
	localparam int MagW   = 52;
	localparam int RadW   = 64;
	localparam int RootW  = 32;

	// Register reset value: 10.0 in Q.8.
	localparam logic [23:0] ThrReset = 24'd2560;
	// Normalization limit for the angle operands.
	localparam logic [MagW-1:0] NormLimit = 52'd1073741824;
	localparam logic [15:0] AngleMax = 16'd46080;
	localparam logic [15:0] IndexMax = 16'hFFFF;

	// Operand sources of the shared multiplier.
	localparam logic [3:0] SRC_DX = 4'd0;
	localparam logic [3:0] SRC_DY = 4'd1;
	localparam logic [3:0] SRC_DZ = 4'd2;
	localparam logic [3:0] SRC_AX = 4'd3;
	localparam logic [3:0] SRC_AY = 4'd4;
	localparam logic [3:0] SRC_AZ = 4'd5;
	localparam logic [3:0] SRC_BX = 4'd6;
	localparam logic [3:0] SRC_BY = 4'd7;
	localparam logic [3:0] SRC_BZ = 4'd8;
	localparam logic [3:0] SRC_UX = 4'd9;
	localparam logic [3:0] SRC_UY = 4'd10;
	localparam logic [3:0] SRC_UZ = 4'd11;

	// Multiply-accumulate program steps.
	localparam logic [3:0] OP_STEP_END  = 4'd2;
	localparam logic [3:0] OP_CROSS_X   = 4'd3;
	localparam logic [3:0] OP_CROSS_XE  = 4'd4;
	localparam logic [3:0] OP_CROSS_YE  = 4'd6;
	localparam logic [3:0] OP_CROSS_ZE  = 4'd8;
	localparam logic [3:0] OP_DOT_END   = 4'd11;
	localparam logic [3:0] OP_SQ_FIRST  = 4'd12;
	localparam logic [3:0] OP_SQ_END    = 4'd14;

	typedef struct packed {
		logic [3:0] sel_a;
		logic [3:0] sel_b;
		logic       neg;
		logic       last;
	} mop_t;

	function automatic mop_t mop_f(input logic [3:0] k);
		mop_t m;
		m = '{sel_a: SRC_DX, sel_b: SRC_DX, neg: 1'b0, last: 1'b0};
		case (k)
			4'd0:  m = '{SRC_DX, SRC_DX, 1'b0, 1'b0};
			4'd1:  m = '{SRC_DY, SRC_DY, 1'b0, 1'b0};
			4'd2:  m = '{SRC_DZ, SRC_DZ, 1'b0, 1'b1};
			4'd3:  m = '{SRC_AY, SRC_BZ, 1'b0, 1'b0};
			4'd4:  m = '{SRC_AZ, SRC_BY, 1'b1, 1'b1};
			4'd5:  m = '{SRC_AZ, SRC_BX, 1'b0, 1'b0};
			4'd6:  m = '{SRC_AX, SRC_BZ, 1'b1, 1'b1};
			4'd7:  m = '{SRC_AX, SRC_BY, 1'b0, 1'b0};
			4'd8:  m = '{SRC_AY, SRC_BX, 1'b1, 1'b1};
			4'd9:  m = '{SRC_AX, SRC_BX, 1'b0, 1'b0};
			4'd10: m = '{SRC_AY, SRC_BY, 1'b0, 1'b0};
			4'd11: m = '{SRC_AZ, SRC_BZ, 1'b0, 1'b1};
			4'd12: m = '{SRC_UX, SRC_UX, 1'b0, 1'b0};
			4'd13: m = '{SRC_UY, SRC_UY, 1'b0, 1'b0};
			4'd14: m = '{SRC_UZ, SRC_UZ, 1'b0, 1'b1};
			default: m = '{SRC_DX, SRC_DX, 1'b0, 1'b1};
		endcase
		return m;
	endfunction

	// atan(2^-i) in degrees times 65536, rounded to nearest.
	function automatic logic [21:0] atan_f(input logic [4:0] i);
		logic [21:0] v;
		case (i)
			5'd0:  v = 22'd2949120;
			5'd1:  v = 22'd1740967;
			5'd2:  v = 22'd919879;
			5'd3:  v = 22'd466945;
			5'd4:  v = 22'd234379;
			5'd5:  v = 22'd117304;
			5'd6:  v = 22'd58666;
			5'd7:  v = 22'd29335;
			5'd8:  v = 22'd14668;
			5'd9:  v = 22'd7334;
			5'd10: v = 22'd3667;
			5'd11: v = 22'd1833;
			5'd12: v = 22'd917;
			5'd13: v = 22'd458;
			5'd14: v = 22'd229;
			5'd15: v = 22'd115;
			5'd16: v = 22'd57;
			5'd17: v = 22'd29;
			5'd18: v = 22'd14;
			5'd19: v = 22'd7;
			5'd20: v = 22'd4;
			5'd21: v = 22'd2;
			5'd22: v = 22'd1;
			default: v = 22'd0;
		endcase
		return v;
	endfunction

endpackage

// ----- sv/tssa_isqrt.sv -----
`timescale 1ns / 1ps
// Bit-serial integer square root, two radicand bits per cycle.
// Depends on tssa_pkg for widths.
module tssa_isqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [tssa_pkg::RadW-1:0]  rad,
	output logic                       busy,
	output logic                       done,
	output logic [tssa_pkg::RootW-1:0] root
);

	logic [tssa_pkg::RadW-1:0]  rad_q;
	logic [33:0]                rem_q;
	logic [tssa_pkg::RootW-1:0] root_q;
	logic [4:0]                 cnt_q;
	logic                       busy_q, done_q;
	logic [35:0]                rem_sh, trial;

	assign rem_sh = {rem_q, rad_q[tssa_pkg::RadW-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= rad;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[tssa_pkg::RadW-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= 34'(rem_sh - trial);
				root_q <= {root_q[tssa_pkg::RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh[33:0];
				root_q <= {root_q[tssa_pkg::RootW-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign root = root_q;

endmodule

// ----- sv/tssa_cordic.sv -----
`timescale 1ns / 1ps
// Vectoring CORDIC, one rotation per cycle, giving the chord angle in Q8.8 degrees.
// Depends on tssa_pkg for the arctangent table and angle limits.
module tssa_cordic #(
	parameter int ITER = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [30:0] x_init,
	input  logic [31:0] y_init,
	input  logic        mirror,
	output logic        done,
	output logic [15:0] angle
);

	localparam int NIter = (ITER > 24) ? 24 : ITER;
	localparam logic [4:0] NLast = 5'(NIter);

	logic signed [35:0] x_q, y_q, xs, ys;
	logic [35:0]        xa, ya;
	logic signed [26:0] z_q, at;
	logic [4:0]         i_q;
	logic               busy_q, done_q, mirror_q;
	logic [15:0]        angle_q;
	logic [24:0]        zc, ang;
	logic [16:0]        rnd;

	always_comb begin
		xa = x_q[35] ? 36'(-x_q) : 36'(x_q);
		ya = y_q[35] ? 36'(-y_q) : 36'(y_q);
		xs = x_q[35] ? -$signed(xa >> i_q) : $signed(xa >> i_q);
		ys = y_q[35] ? -$signed(ya >> i_q) : $signed(ya >> i_q);
		at = $signed({5'b0, tssa_pkg::atan_f(i_q)});
		if (z_q[26]) zc = '0;
		else if (z_q > 27'sd5898240) zc = 25'd5898240;
		else zc = z_q[24:0];
		ang = mirror_q ? 25'(25'd11796480 - zc) : zc;
		rnd = 17'((ang + 25'd128) >> 8);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == NLast) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					i_q <= i_q + 5'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q      <= $signed({5'b0, x_init});
			y_q      <= $signed({4'b0, y_init});
			z_q      <= '0;
			mirror_q <= mirror;
		end else if (busy_q) begin
			if (i_q == NLast) begin
				angle_q <= (rnd > 17'(tssa_pkg::AngleMax)) ? tssa_pkg::AngleMax : rnd[15:0];
			end else if (y_q > 36'sd0) begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end else begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end
		end
	end

	assign done  = done_q;
	assign angle = angle_q;

endmodule

// ----- sv/track_segment_scatter_angle.sv -----
`timescale 1ns / 1ps
// Top level of the track segmentation block: sequencer, shared multiplier and state.
// Depends on tssa_pkg, tssa_isqrt and tssa_cordic.
//
// Points of one track enter on the input channel (pos_x/pos_y/pos_z in Q15.8,
// last_point marking the final point). A word is taken when in_valid is high and
// in_stall is low. in_stall is high while a point is being worked on, so the block
// holds one point at a time. The first point of a track only loads the state and
// the next word can be taken in the next cycle. Every later point uses the shared
// 32x32 multiplier for the squared step, then the bit-serial square root, an
// update state and the idle state. A point that closes a segment also passes
// through the output state, handing its result over. When it has a previous
// chord and neither chord is zero it also adds nine multiplier passes for the
// cross and dot products, operand normalization, three squares, a second square
// root and the CORDIC. The square root unit takes the largest share of the work
// on an ordinary point. A closed segment leaves one word on the output channel,
// held in a result register until out_stall is low; while that word waits the
// next point is taken, and the sequencer only pauses when a second result is ready.
// The user must write the threshold register through cfg_valid/cfg_ready/cfg_data
// only while the block is idle; the block itself does not enforce this.
// Reset clears the track state and loads 10.0 as threshold.
module track_segment_scatter_angle #(
	parameter int CORDIC_ITERATIONS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic               last_point,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [31:0]        segment_length,
	output logic [15:0]        break_index,
	output logic [15:0]        angle_deg,
	output logic               angle_valid,
	output logic               degenerate,
	output logic               end_of_track,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [23:0]        cfg_data
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_MUL   = 4'd1;
	localparam logic [3:0] S_ACC   = 4'd2;
	localparam logic [3:0] S_SQST  = 4'd3;
	localparam logic [3:0] S_UPD   = 4'd4;
	localparam logic [3:0] S_NORM  = 4'd5;
	localparam logic [3:0] S_SQANG = 4'd6;
	localparam logic [3:0] S_CORD  = 4'd7;
	localparam logic [3:0] S_OUT   = 4'd8;

	logic [3:0] state_q;

	// Configuration and track state.
	logic [23:0]        thr_q;
	logic               have_point_q, have_pdir_q;
	logic signed [23:0] prev_x_q, prev_y_q, prev_z_q;
	logic signed [23:0] start_x_q, start_y_q, start_z_q;
	logic signed [24:0] pdir_x_q, pdir_y_q, pdir_z_q;
	logic [31:0]        run_q;
	logic [15:0]        count_q;

	// Working registers of the current point.
	logic signed [23:0] px_q, py_q, pz_q;
	logic               last_q;
	logic signed [24:0] dx_q, dy_q, dz_q;
	logic signed [24:0] chx_q, chy_q, chz_q;
	logic [3:0]         k_q;
	logic signed [tssa_pkg::ProdW-1:0] prod_q, acc_q, acc_n;
	logic [tssa_pkg::MagW-1:0] ux_q, uy_q, uz_q, ud_q;
	logic               dneg_q;
	logic [15:0]        idx_q, ang_q;
	logic               aval_q, degen_q;

	// Result register.
	logic               ov_q;
	logic [31:0]        o_len_q;
	logic [15:0]        o_idx_q, o_ang_q;
	logic               o_aval_q, o_degen_q, o_eot_q;

	tssa_pkg::mop_t mop;
	logic signed [tssa_pkg::OperW-1:0] src [12];
	logic signed [tssa_pkg::OperW-1:0] opa, opb;

	logic       accept, out_free;
	logic [32:0] sum;
	logic [31:0] run_n;
	logic [15:0] idx_n;
	logic        close;
	logic signed [24:0] cx_n, cy_n, cz_n;
	logic        ch_zero, pdir_zero;
	logic [tssa_pkg::ProdW-1:0] acc_abs;
	logic        big;

	logic                         sq_start, sq_busy, sq_done;
	logic [tssa_pkg::RadW-1:0]    sq_rad;
	logic [tssa_pkg::RootW-1:0]   sq_root;
	logic                         cd_start, cd_done;
	logic [15:0]                  cd_angle;

	assign accept    = in_valid && !in_stall;
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_free  = !ov_q || !out_stall;

	// Operand selection for the shared multiplier.
	always_comb begin
		src[0]  = tssa_pkg::OperW'(dx_q);
		src[1]  = tssa_pkg::OperW'(dy_q);
		src[2]  = tssa_pkg::OperW'(dz_q);
		src[3]  = tssa_pkg::OperW'(pdir_x_q);
		src[4]  = tssa_pkg::OperW'(pdir_y_q);
		src[5]  = tssa_pkg::OperW'(pdir_z_q);
		src[6]  = tssa_pkg::OperW'(chx_q);
		src[7]  = tssa_pkg::OperW'(chy_q);
		src[8]  = tssa_pkg::OperW'(chz_q);
		src[9]  = $signed({1'b0, ux_q[30:0]});
		src[10] = $signed({1'b0, uy_q[30:0]});
		src[11] = $signed({1'b0, uz_q[30:0]});
		mop = tssa_pkg::mop_f(k_q);
		opa = (mop.sel_a < 4'd12) ? src[mop.sel_a] : '0;
		opb = (mop.sel_b < 4'd12) ? src[mop.sel_b] : '0;
		acc_n = mop.neg ? acc_q - prod_q : acc_q + prod_q;
		acc_abs = acc_n[tssa_pkg::ProdW-1] ? tssa_pkg::ProdW'(-acc_n)
			: tssa_pkg::ProdW'(acc_n);
	end

	// Step bookkeeping used when the step length is ready.
	always_comb begin
		sum   = {1'b0, run_q} + {1'b0, sq_root};
		run_n = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
		idx_n = (count_q < tssa_pkg::IndexMax) ? 16'(count_q + 16'd1) : tssa_pkg::IndexMax;
		close = (run_n >= {8'b0, thr_q}) || (last_q && run_n != 32'd0);
		cx_n  = 25'(px_q) - 25'(start_x_q);
		cy_n  = 25'(py_q) - 25'(start_y_q);
		cz_n  = 25'(pz_q) - 25'(start_z_q);
		ch_zero   = (cx_n == '0) && (cy_n == '0) && (cz_n == '0);
		pdir_zero = (pdir_x_q == '0) && (pdir_y_q == '0) && (pdir_z_q == '0);
		big = (ux_q > tssa_pkg::NormLimit) || (uy_q > tssa_pkg::NormLimit) ||
			(uz_q > tssa_pkg::NormLimit) || (ud_q > tssa_pkg::NormLimit);
	end

	assign sq_start = (state_q == S_ACC) && mop.last &&
		((k_q == tssa_pkg::OP_STEP_END) || (k_q == tssa_pkg::OP_SQ_END));
	assign sq_rad   = acc_n;
	assign cd_start = (state_q == S_SQANG) && sq_done;

	tssa_isqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.rad    (sq_rad),
		.busy   (sq_busy),
		.done   (sq_done),
		.root   (sq_root)
	);

	tssa_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cd_start),
		.x_init (ud_q[30:0]),
		.y_init (sq_root),
		.mirror (dneg_q),
		.done   (cd_done),
		.angle  (cd_angle)
	);

	// Sequencer and track state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			thr_q        <= tssa_pkg::ThrReset;
			have_point_q <= 1'b0;
			have_pdir_q  <= 1'b0;
			prev_x_q     <= '0;
			prev_y_q     <= '0;
			prev_z_q     <= '0;
			start_x_q    <= '0;
			start_y_q    <= '0;
			start_z_q    <= '0;
			pdir_x_q     <= '0;
			pdir_y_q     <= '0;
			pdir_z_q     <= '0;
			run_q        <= '0;
			count_q      <= '0;
			ov_q         <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				thr_q <= cfg_data;
			end
			// The result register fills when the sequencer hands over a word
			// and empties when the receiver takes it.
			if (state_q == S_OUT && out_free) begin
				ov_q <= 1'b1;
			end else if (!out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (!have_point_q) begin
							// A new track begins; a lone last point leaves nothing.
							have_pdir_q  <= 1'b0;
							pdir_x_q     <= '0;
							pdir_y_q     <= '0;
							pdir_z_q     <= '0;
							run_q        <= '0;
							count_q      <= '0;
							have_point_q <= !last_point;
							prev_x_q     <= last_point ? '0 : pos_x;
							prev_y_q     <= last_point ? '0 : pos_y;
							prev_z_q     <= last_point ? '0 : pos_z;
							start_x_q    <= last_point ? '0 : pos_x;
							start_y_q    <= last_point ? '0 : pos_y;
							start_z_q    <= last_point ? '0 : pos_z;
						end else begin
							state_q <= S_MUL;
						end
					end
				end
				S_MUL: begin
					state_q <= S_ACC;
				end
				S_ACC: begin
					if (!mop.last) begin
						state_q <= S_MUL;
					end else if (k_q == tssa_pkg::OP_STEP_END) begin
						state_q <= S_SQST;
					end else if (k_q == tssa_pkg::OP_DOT_END) begin
						state_q <= S_NORM;
					end else if (k_q == tssa_pkg::OP_SQ_END) begin
						state_q <= S_SQANG;
					end else begin
						state_q <= S_MUL;
					end
				end
				S_SQST: begin
					if (sq_done) begin
						state_q <= S_UPD;
					end
				end
				S_UPD: begin
					if (!close && last_q) begin
						// The track ends without a leftover segment.
						state_q      <= S_IDLE;
						have_point_q <= 1'b0;
						have_pdir_q  <= 1'b0;
						prev_x_q     <= '0;
						prev_y_q     <= '0;
						prev_z_q     <= '0;
						start_x_q    <= '0;
						start_y_q    <= '0;
						start_z_q    <= '0;
						pdir_x_q     <= '0;
						pdir_y_q     <= '0;
						pdir_z_q     <= '0;
						run_q        <= '0;
						count_q      <= '0;
					end else begin
						run_q    <= run_n;
						count_q  <= idx_n;
						prev_x_q <= px_q;
						prev_y_q <= py_q;
						prev_z_q <= pz_q;
						if (!close) begin
							state_q <= S_IDLE;
						end else if (have_pdir_q && !ch_zero && !pdir_zero) begin
							state_q <= S_MUL;
						end else begin
							state_q <= S_OUT;
						end
					end
				end
				S_NORM: begin
					if (!big) begin
						state_q <= S_MUL;
					end
				end
				S_SQANG: begin
					if (sq_done) begin
						state_q <= S_CORD;
					end
				end
				S_CORD: begin
					if (cd_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (out_free) begin
						state_q <= S_IDLE;
						run_q   <= '0;
						if (last_q) begin
							have_point_q <= 1'b0;
							have_pdir_q  <= 1'b0;
							prev_x_q     <= '0;
							prev_y_q     <= '0;
							prev_z_q     <= '0;
							start_x_q    <= '0;
							start_y_q    <= '0;
							start_z_q    <= '0;
							pdir_x_q     <= '0;
							pdir_y_q     <= '0;
							pdir_z_q     <= '0;
							count_q      <= '0;
						end else begin
							have_pdir_q <= 1'b1;
							pdir_x_q    <= chx_q;
							pdir_y_q    <= chy_q;
							pdir_z_q    <= chz_q;
							start_x_q   <= px_q;
							start_y_q   <= py_q;
							start_z_q   <= pz_q;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers of the point in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				px_q   <= pos_x;
				py_q   <= pos_y;
				pz_q   <= pos_z;
				last_q <= last_point;
				dx_q   <= 25'(pos_x) - 25'(prev_x_q);
				dy_q   <= 25'(pos_y) - 25'(prev_y_q);
				dz_q   <= 25'(pos_z) - 25'(prev_z_q);
				k_q    <= '0;
				acc_q  <= '0;
			end
			S_MUL: begin
				prod_q <= opa * opb;
			end
			S_ACC: begin
				k_q   <= k_q + 4'd1;
				acc_q <= mop.last ? '0 : acc_n;
				if (mop.last) begin
					if (k_q == tssa_pkg::OP_CROSS_XE) ux_q <= acc_abs[tssa_pkg::MagW-1:0];
					if (k_q == tssa_pkg::OP_CROSS_YE) uy_q <= acc_abs[tssa_pkg::MagW-1:0];
					if (k_q == tssa_pkg::OP_CROSS_ZE) uz_q <= acc_abs[tssa_pkg::MagW-1:0];
					if (k_q == tssa_pkg::OP_DOT_END) begin
						ud_q   <= acc_abs[tssa_pkg::MagW-1:0];
						dneg_q <= acc_n[tssa_pkg::ProdW-1];
					end
				end
			end
			S_UPD: begin
				idx_q   <= idx_n;
				chx_q   <= cx_n;
				chy_q   <= cy_n;
				chz_q   <= cz_n;
				k_q     <= tssa_pkg::OP_CROSS_X;
				acc_q   <= '0;
				ang_q   <= '0;
				aval_q  <= have_pdir_q;
				degen_q <= have_pdir_q && (ch_zero || pdir_zero);
			end
			S_NORM: begin
				// One right shift per cycle until every operand fits in 31 bits.
				if (big) begin
					ux_q <= ux_q >> 1;
					uy_q <= uy_q >> 1;
					uz_q <= uz_q >> 1;
					ud_q <= ud_q >> 1;
				end else begin
					k_q <= tssa_pkg::OP_SQ_FIRST;
				end
			end
			S_CORD: begin
				if (cd_done) begin
					ang_q <= cd_angle;
				end
			end
			S_OUT: begin
				if (out_free) begin
					o_len_q   <= run_q;
					o_idx_q   <= idx_q;
					o_ang_q   <= ang_q;
					o_aval_q  <= aval_q;
					o_degen_q <= degen_q;
					o_eot_q   <= last_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid      = ov_q;
	assign segment_length = o_len_q;
	assign break_index    = o_idx_q;
	assign angle_deg      = o_ang_q;
	assign angle_valid    = o_aval_q;
	assign degenerate     = o_degen_q;
	assign end_of_track   = o_eot_q;

`ifndef NO_ASSERTIONS
	a_sqrt_owned: assert property (@(posedge clk) disable iff (!arst_n)
		sq_busy |-> (state_q == S_SQST || state_q == S_SQANG))
		else $error("square root busy outside its states");
	a_degen_angle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && degenerate) |-> (angle_valid && angle_deg == 16'd0))
		else $error("degenerate result with angle");
	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !angle_valid) |-> (angle_deg == 16'd0 && !degenerate))
		else $error("angle given without previous chord");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_OUT && !out_free) |=> (state_q == S_OUT))
		else $error("result dropped while output busy");
`endif

endmodule

// ----- sim/tssa_segment_checker.sv -----
`timescale 1ns / 1ps
// Watches the point, result and threshold channels of the track segmentation block,
// predicts every closed segment and compares it with the word that comes out.
// Depends on nothing beyond the port list of track_segment_scatter_angle.
module tssa_segment_checker #(
	parameter int ITERS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic signed [23:0] pos_x,
	input  logic signed [23:0] pos_y,
	input  logic signed [23:0] pos_z,
	input  logic               last_point,
	input  logic               out_valid,
	input  logic               out_stall,
	input  logic [31:0]        segment_length,
	input  logic [15:0]        break_index,
	input  logic [15:0]        angle_deg,
	input  logic               angle_valid,
	input  logic               degenerate,
	input  logic               end_of_track,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [23:0]        cfg_data,
	output int                 mismatches,
	output int                 pending
);

	typedef struct {
		logic [31:0] len;
		logic [15:0] idx;
		logic [15:0] ang;
		logic        av;
		logic        dg;
		logic        eot;
	} seg_result_t;

	localparam longint AtanQ16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	seg_result_t segments_due[$];

	logic [23:0] threshold;
	logic        tracking, have_chord;
	longint      last_x, last_y, last_z, start_x, start_y, start_z;
	longint      chord_x, chord_y, chord_z;
	logic [31:0] path_len;
	logic [15:0] point_idx;

	function automatic longint unsigned isqrt_u64(longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'h1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v = v - (r + b);
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic longint unsigned mag(longint v);
		return (v < 0) ? longint'(-v) : v;
	endfunction

	// Right shift that rounds toward zero for negative values.
	function automatic longint shr_tz(longint v, int s);
		longint unsigned u;
		if (v < 0) begin
			u = longint'(-v);
			return -longint'(u >> s);
		end
		u = v;
		return longint'(u >> s);
	endfunction

	// Angle between two nonzero chords in Q8.8 degrees, by vectoring CORDIC.
	function automatic logic [15:0] chord_angle_q88(longint ax, longint ay, longint az,
			longint bx, longint by, longint bz);
		longint cx, cy, cz, dt, x, y, z, xs, ys, ang;
		longint unsigned ux, uy, uz, ud, m;
		int s, n;
		cx = ay * bz - az * by;
		cy = az * bx - ax * bz;
		cz = ax * by - ay * bx;
		dt = ax * bx + ay * by + az * bz;
		ux = mag(cx);
		uy = mag(cy);
		uz = mag(cz);
		ud = mag(dt);
		m = ux;
		if (uy > m) m = uy;
		if (uz > m) m = uz;
		if (ud > m) m = ud;
		s = 0;
		while ((m >> s) > (64'd1 << 30)) s++;
		ux >>= s;
		uy >>= s;
		uz >>= s;
		ud >>= s;
		y = longint'(isqrt_u64(ux * ux + uy * uy + uz * uz));
		x = longint'(ud);
		z = 0;
		n = (ITERS > 24) ? 24 : ITERS;
		for (int i = 0; i < n; i++) begin
			xs = shr_tz(x, i);
			ys = shr_tz(y, i);
			if (y > 0) begin
				x += ys;
				y -= xs;
				z += AtanQ16[i];
			end else begin
				x -= ys;
				y += xs;
				z -= AtanQ16[i];
			end
		end
		if (z < 0) z = 0;
		if (z > 90 * 65536) z = 90 * 65536;
		ang = (dt < 0) ? 180 * 65536 - z : z;
		ang = (ang + 128) >>> 8;
		if (ang > 46080) ang = 46080;
		return ang[15:0];
	endfunction

	task automatic clear_track();
		tracking = 1'b0;
		have_chord = 1'b0;
		last_x = 0; last_y = 0; last_z = 0;
		start_x = 0; start_y = 0; start_z = 0;
		chord_x = 0; chord_y = 0; chord_z = 0;
		path_len = 0;
		point_idx = 0;
	endtask

	task automatic predict_point(longint px, longint py, longint pz, logic fin);
		longint dx, dy, dz, chx, chy, chz;
		longint unsigned step, sum;
		seg_result_t r;
		if (!tracking) begin
			clear_track();
			if (!fin) begin
				tracking = 1'b1;
				last_x = px; last_y = py; last_z = pz;
				start_x = px; start_y = py; start_z = pz;
			end
			return;
		end
		dx = px - last_x;
		dy = py - last_y;
		dz = pz - last_z;
		step = isqrt_u64(dx * dx + dy * dy + dz * dz);
		sum = path_len + step;
		path_len = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
		if (point_idx != 16'hFFFF) point_idx++;
		last_x = px; last_y = py; last_z = pz;
		if (!(path_len >= {8'd0, threshold} || (fin && path_len != 0))) begin
			if (fin) clear_track();
			return;
		end
		chx = px - start_x;
		chy = py - start_y;
		chz = pz - start_z;
		r.len = path_len;
		r.idx = point_idx;
		r.ang = 0;
		r.av = have_chord;
		r.dg = 1'b0;
		r.eot = fin;
		if (have_chord) begin
			// A zero chord on either side has no direction, so no angle.
			if ((chx == 0 && chy == 0 && chz == 0) ||
					(chord_x == 0 && chord_y == 0 && chord_z == 0))
				r.dg = 1'b1;
			else
				r.ang = chord_angle_q88(chord_x, chord_y, chord_z, chx, chy, chz);
		end
		segments_due = {segments_due, r};
		chord_x = chx; chord_y = chy; chord_z = chz;
		have_chord = 1'b1;
		start_x = px; start_y = py; start_z = pz;
		path_len = 0;
		if (fin) clear_track();
	endtask

	always @(posedge clk or negedge arst_n) begin
		seg_result_t e;
		if (!arst_n) begin
			segments_due.delete();
			threshold <= 24'd2560;
			clear_track();
			mismatches <= 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (segments_due.size() == 0) begin
					if (mismatches < 10)
						$display("unexpected segment word: len %0d idx %0d", segment_length,
							break_index);
					mismatches <= mismatches + 1;
				end else begin
					e = segments_due.pop_front();
					if (segment_length !== e.len || break_index !== e.idx ||
							angle_deg !== e.ang || angle_valid !== e.av ||
							degenerate !== e.dg || end_of_track !== e.eot) begin
						if (mismatches < 10)
							$display("segment mismatch: exp len %0d idx %0d ang %0d av %0b dg %0b eot %0b, got len %0d idx %0d ang %0d av %0b dg %0b eot %0b",
								e.len, e.idx, e.ang, e.av, e.dg, e.eot, segment_length,
								break_index, angle_deg, angle_valid, degenerate, end_of_track);
						mismatches <= mismatches + 1;
					end
				end
			end
			if (cfg_valid && cfg_ready) threshold <= cfg_data;
			if (in_valid && !in_stall)
				predict_point(longint'(pos_x), longint'(pos_y), longint'(pos_z), last_point);
		end
		pending <= segments_due.size();
	end

endmodule

// ----- sim/tb_track_segment_scatter_angle.sv -----
`timescale 1ns / 1ps
// Stimulus and verdict for the track segmentation block; the checker does the predicting.
// Depends on track_segment_scatter_angle and tssa_segment_checker.
module tb_track_segment_scatter_angle;

	// The drain wait and the cycle limit are sized well above the time the block
	// takes on a point that closes an angled segment.
	localparam int DrainCycles = 400;
	localparam int CycleLimit  = 3000000;
	localparam int PosMin      = -8388608;
	localparam int PosMax      = 8388607;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic signed [23:0] pos_x, pos_y, pos_z;
	logic               last_point;
	logic               out_valid;
	logic               out_stall;
	logic [31:0]        segment_length;
	logic [15:0]        break_index;
	logic [15:0]        angle_deg;
	logic               angle_valid, degenerate, end_of_track;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [23:0]        cfg_data;
	int                 mismatches, pending;

	// Idling control shared by the sender and the receiver, the watchdog count and the current threshold.
	bit  idle_en;
	bit  hold_req;
	int  cycles;
	int  thr_now;

	track_segment_scatter_angle dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_point(last_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.segment_length(segment_length), .break_index(break_index),
		.angle_deg(angle_deg), .angle_valid(angle_valid),
		.degenerate(degenerate), .end_of_track(end_of_track),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	tssa_segment_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.pos_x(pos_x), .pos_y(pos_y), .pos_z(pos_z), .last_point(last_point),
		.out_valid(out_valid), .out_stall(out_stall),
		.segment_length(segment_length), .break_index(break_index),
		.angle_deg(angle_deg), .angle_valid(angle_valid),
		.degenerate(degenerate), .end_of_track(end_of_track),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.mismatches(mismatches), .pending(pending)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// Receiver: short random stall bursts while idling is enabled, and one long hold-off on request so
	// that the result register fills and the block stalls its input.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				hold_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a run that hangs ends here.
	initial begin
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int clamp_pos(longint v);
		if (v < PosMin) return PosMin;
		if (v > PosMax) return PosMax;
		return int'(v);
	endfunction

	// Offers one point word and returns at the edge where it is taken. The
	// caller is always at a rising edge, so in_valid gets one assignment per step.
	task automatic send_point(int x, int y, int z, bit fin);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		pos_x <= x[23:0];
		pos_y <= y[23:0];
		pos_z <= z[23:0];
		last_point <= fin;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
	endtask

	// Lets the block finish all work, then writes a new threshold.
	task automatic set_threshold(int v);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		cfg_data <= v[23:0];
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		thr_now = v;
	endtask

	// One random track. Most are random walks whose step size follows the
	// threshold so that segments close often; some points are pure noise.
	task automatic random_track(inout int budget);
		int n, x, y, z, span;
		span = (thr_now > 4000000) ? 4000000 : thr_now;
		span = span / 2 + 1;
		n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 12);
		x = $signed($urandom() % 24'hFFFFFF) - PosMax;
		y = $signed($urandom() % 24'hFFFFFF) - PosMax;
		z = $signed($urandom() % 24'hFFFFFF) - PosMax;
		for (int i = 0; i < n && budget > 0; i++) begin
			case ($urandom_range(0, 9))
				0: begin
					x = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
					y = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
					z = int'($urandom_range(0, 24'hFFFFFF)) + PosMin;
				end
				1: ; // repeated point, zero step
				default: begin
					x = clamp_pos(longint'(x) + $urandom_range(0, 2 * span) - span);
					y = clamp_pos(longint'(y) + $urandom_range(0, 2 * span) - span);
					z = clamp_pos(longint'(z) + $urandom_range(0, 2 * span) - span);
				end
			endcase
			send_point(x, y, z, (i == n - 1) || budget == 1);
			budget--;
		end
	endtask

	task automatic random_phase(int items, bit with_hold);
		int budget;
		bit held;
		budget = items;
		held = 1'b0;
		while (budget > 0) begin
			if (with_hold && !held && budget < items / 2) begin
				hold_req = 1'b1;
				held = 1'b1;
			end
			random_track(budget);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		pos_x = '0;
		pos_y = '0;
		pos_z = '0;
		last_point = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		idle_en = 1'b1;
		hold_req = 1'b0;
		thr_now = 2560;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset threshold of 10.0.
		// Coordinate extremes, with the full diagonal as the largest step.
		send_point(PosMin, PosMin, PosMin, 1'b0);
		send_point(PosMax, PosMax, PosMax, 1'b0);
		send_point(PosMin, PosMax, 0, 1'b0);
		send_point(PosMax, PosMin, PosMax, 1'b1);
		// A track of a single point gives nothing.
		send_point(1234, -77, 5, 1'b1);
		// Last point with no leftover length: no word, the track still ends.
		send_point(0, 0, 0, 1'b0);
		send_point(3000, 0, 0, 1'b0);
		send_point(3000, 0, 0, 1'b1);
		// Straight back along the chord gives 180 degrees.
		send_point(0, 0, 0, 1'b0);
		send_point(3000, 0, 0, 1'b0);
		send_point(0, 0, 0, 1'b0);
		// A segment that returns to its own start has a zero chord.
		send_point(3000, 0, 0, 1'b0);
		send_point(4500, 0, 0, 1'b0);
		send_point(3000, 0, 0, 1'b0);
		// A segment after the zero chord, then a short leftover at a right angle closed by the last point.
		send_point(3000, 3000, 0, 1'b0);
		send_point(3000, 3000, 100, 1'b1);
		// Shallow angle between long chords.
		send_point(0, 0, 0, 1'b0);
		send_point(8000000, 0, 0, 1'b0);
		send_point(PosMax, 1, 0, 1'b0);
		send_point(PosMax, 2, -1, 1'b1);

		random_phase(110, 1'b0);
		set_threshold(1);
		random_phase(110, 1'b1);
		set_threshold(16777215);
		random_phase(90, 1'b0);
		set_threshold(256);
		random_phase(110, 1'b0);
		set_threshold($urandom_range(1, 24'hFFFFFF));
		random_phase(100, 1'b0);
		set_threshold(5000);
		// Last stretch runs without idling on either side.
		idle_en = 1'b0;
		random_phase(160, 1'b0);
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ----- track_segment_scatter_angle.f -----
sv/tssa_pkg.sv
sv/tssa_isqrt.sv
sv/tssa_cordic.sv
sv/track_segment_scatter_angle.sv
sim/tssa_segment_checker.sv
sim/tb_track_segment_scatter_angle.sv
